// File: src/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and ring helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH  = 32;
    localparam int ITEM_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [OCC_W-1:0]         occ_t;
    typedef logic signed [ITEM_W-1:0] item_t;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_TRAVERSE   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_POP_BACK   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        func_t op;
        item_t item;
    } cmd_t;

    // ring position of base + off, with off below DEPTH
    function automatic idx_t ring_pos(input idx_t base, input occ_t off);
        logic [OCC_W:0] sum;
        sum = {{(OCC_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (OCC_W + 1)'(DEPTH))
        begin
            sum = sum - (OCC_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t ring_inc(input idx_t base);
        return (base == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(base + 1'b1);
    endfunction

    function automatic idx_t ring_dec(input idx_t base);
        return (base == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(base - 1'b1);
    endfunction

endpackage

// File: src/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit items held in a ring RAM.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   in_valid / in_stall   func, item_in
//  result    out_valid / out_stall item_out, status, last
//
//  Push, and any full or empty answer: result registered on the take.
//  Pop: registered read of the entry RAM, then the output register via S_RD.
//  Traverse: one item per cycle after the first read while not stalled.
//  Reset clears pointers, occupancy and queues; the RAM is not cleared.
//  A stalled result holds the execution side; the two-entry command buffer
//  keeps accepting requests until it fills.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    func,
    input  logic signed [dq_pkg::ITEM_W-1:0] item_in,
    output logic          out_valid,
    input  logic          out_stall,
    output logic signed [dq_pkg::ITEM_W-1:0] item_out,
    output logic [1:0]    status,
    output logic          last
);
    import dq_pkg::*;

    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_take;
    status_t status_int;

    dq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .item_in   (item_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    dq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .item_out  (item_out),
        .status    (status_int),
        .last      (last)
    );

    assign status = status_int;

endmodule

// File: src/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/dq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_front
// Request intake: decodes the operation code, drops unused codes and queues
// commands in a two-entry buffer towards the execution side.
// ----------------------------------------------------------------------------
module dq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [2:0]    func,
    input  dq_pkg::item_t item_in,
    output logic          cmd_valid,
    output dq_pkg::cmd_t  cmd,
    input  logic          cmd_take
);
    import dq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       code_ok;
    logic       push;
    logic       pop;

    always_comb
    begin
        unique case (func_t'(func))
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_TRAVERSE, FN_POP_FRONT, FN_POP_BACK:
                code_ok = 1'b1;
            default:
                code_ok = 1'b0;
        endcase
    end

    assign in_stall  = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    assign push = in_valid && !in_stall && code_ok;
    assign pop  = cmd_valid && cmd_take;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: func_t'(func), item: item_in};
        end
    end

endmodule

// File: src/dq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_back
// Execution side: holds the front pointer and occupancy, drives the entry RAM and the
// output register, and walks the ring for traversal.
// ----------------------------------------------------------------------------
module dq_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  dq_pkg::cmd_t     cmd,
    output logic             cmd_take,
    output logic             out_valid,
    input  logic             out_stall,
    output dq_pkg::item_t    item_out,
    output dq_pkg::status_t  status,
    output logic             last
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_TRAV
    } state_t;

    state_t  state_reg, state_next;
    idx_t    front_reg, front_next;
    occ_t    occ_reg, occ_next;
    occ_t    cnt_reg, cnt_next;
    logic    out_valid_reg, out_valid_next;
    item_t   item_reg, item_next;
    status_t status_reg, status_next;
    logic    last_reg, last_next;

    logic    ram_wr;
    idx_t    ram_wr_addr;
    logic    ram_rd;
    idx_t    ram_rd_addr;
    item_t   ram_rd_data;

    logic    out_free;
    logic    is_full;
    logic    is_empty;
    logic    trav_last;

    dq_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd.item),
        .rd_en   (ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_full   = (occ_reg == OCC_W'(DEPTH));
    assign is_empty  = (occ_reg == '0);
    assign trav_last = (OCC_W'(cnt_reg + 1'b1) == occ_reg);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        item_next      = item_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        cmd_take       = 1'b0;
        ram_wr         = 1'b0;
        ram_wr_addr    = front_reg;
        ram_rd         = 1'b0;
        ram_rd_addr    = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_take  = 1'b1;
                    item_next = '0;
                    last_next = 1'b1;
                    unique case (cmd.op)
                        FN_PUSH_FRONT, FN_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                ram_wr      = 1'b1;
                                occ_next    = OCC_W'(occ_reg + 1'b1);
                                if (cmd.op == FN_PUSH_FRONT)
                                begin
                                    ram_wr_addr = ring_dec(front_reg);
                                    front_next  = ring_dec(front_reg);
                                end
                                else
                                begin
                                    ram_wr_addr = ring_pos(front_reg, occ_reg);
                                end
                            end
                        end
                        FN_TRAVERSE:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                ram_rd      = 1'b1;
                                ram_rd_addr = front_reg;
                                cnt_next    = '0;
                                state_next  = S_TRAV;
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                ram_rd     = 1'b1;
                                occ_next   = OCC_W'(occ_reg - 1'b1);
                                state_next = S_RD;
                                if (cmd.op == FN_POP_FRONT)
                                begin
                                    ram_rd_addr = front_reg;
                                    front_next  = ring_inc(front_reg);
                                end
                                else
                                begin
                                    ram_rd_addr = ring_pos(front_reg,
                                                           OCC_W'(occ_reg - 1'b1));
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    item_next      = ram_rd_data;
                    status_next    = ST_OK;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_TRAV:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    item_next      = ram_rd_data;
                    status_next    = ST_OK;
                    last_next      = trav_last;
                    if (trav_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next    = OCC_W'(cnt_reg + 1'b1);
                        ram_rd      = 1'b1;
                        ram_rd_addr = ring_pos(front_reg, OCC_W'(cnt_reg + 1'b1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            status_reg    <= ST_OK;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            item_reg      <= item_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign item_out  = item_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_trav_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRAV |-> cnt_reg < occ_reg)
        else $error("traversal count past occupancy");

    a_trav_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRAV && out_free && trav_last |=> state_reg == S_IDLE)
        else $error("traversal did not finish on last item");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE && out_free)
        else $error("command taken while busy");

endmodule
